@@ hdl/bfia_pkg.sv @@
// Shared types and constants for the best-fit interval allocator.
`timescale 1ns / 1ps
package bfia_pkg;

    localparam int MAX_FREE_BLOCKS = 64;
    localparam int AW = $clog2(MAX_FREE_BLOCKS);
    localparam int CW = $clog2(MAX_FREE_BLOCKS + 1);

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [31:0] MAX_ROUNDABLE = 32'hFFFF_FFF0;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] req_size;
        logic [31:0] block_offset;
    } t_req;

    typedef struct packed {
        logic [31:0] granted_offset;
        logic [1:0]  status;
        logic [31:0] peak_end;
    } t_rsp;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
    } t_entry;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        t_entry        wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } t_tbl_cmd;

endpackage

@@ hdl/bfia_table.sv @@
// Free-interval table: one write port, one registered read port.
`timescale 1ns / 1ps
module bfia_table (
    input  logic                i_clk,
    input  bfia_pkg::t_tbl_cmd  i_cmd,
    output bfia_pkg::t_entry    o_rdata
);

    bfia_pkg::t_entry r_mem [bfia_pkg::MAX_FREE_BLOCKS];
    bfia_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        if (i_cmd.re) begin
            r_rdata <= r_mem[i_cmd.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/bfia_ctrl.sv @@
// Sequencer and compare/add datapath: scans, shifts and updates the table.
`timescale 1ns / 1ps
module bfia_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  bfia_pkg::t_req      i_req,
    input  logic [31:0]         i_arena,
    input  logic                i_out_free,
    output logic                o_ready,
    output logic                o_done,
    output bfia_pkg::t_rsp      o_rsp,
    output bfia_pkg::t_tbl_cmd  o_cmd,
    input  bfia_pkg::t_entry    i_rdata
);

    localparam int AW = bfia_pkg::AW;
    localparam int CW = bfia_pkg::CW;

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_ASCAN  = 4'd2;
    localparam logic [3:0] S_AAPPLY = 4'd3;
    localparam logic [3:0] S_FSCAN  = 4'd4;
    localparam logic [3:0] S_FAPPLY = 4'd5;
    localparam logic [3:0] S_SHDN   = 4'd6;
    localparam logic [3:0] S_SHUP   = 4'd7;
    localparam logic [3:0] S_FINS   = 4'd8;
    localparam logic [3:0] S_RESP   = 4'd9;

    logic [3:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [31:0]      r_peak, n_peak;
    logic [31:0]      r_need, n_need;
    logic [31:0]      r_off, n_off;
    logic [31:0]      r_granted, n_granted;
    logic [1:0]       r_status, n_status;
    logic [AW-1:0]    r_raddr, n_raddr;
    logic             r_issue, n_issue;
    logic             r_rvld;
    logic [AW-1:0]    r_ridx;
    logic             r_found, n_found;
    logic [AW-1:0]    r_best_idx, n_best_idx;
    bfia_pkg::t_entry r_best, n_best;
    bfia_pkg::t_entry r_prev, n_prev;
    logic             r_prev_v, n_prev_v;
    bfia_pkg::t_entry r_next, n_next;
    logic             r_next_v, n_next_v;
    logic [CW-1:0]    r_pos, n_pos;

    logic [AW-1:0]    last_idx;
    logic [31:0]      full_len;
    logic [32:0]      end_sum;
    logic [31:0]      end_sat;
    logic [32:0]      new_end;
    logic [32:0]      prev_end;
    logic             join_next;
    logic             join_prev;
    logic [33:0]      len_sum;

    function automatic logic [31:0] sat32(input logic [33:0] v);
        logic [31:0] res;
        res = (v[33:32] != 2'b00) ? 32'hFFFF_FFFF : v[31:0];
        return res;
    endfunction

    assign last_idx  = AW'(r_count - CW'(1));
    assign full_len  = (i_arena == 32'd0) ? 32'hFFFF_FFFF : i_arena;
    assign end_sum   = {1'b0, r_best.start} + {1'b0, r_need};
    assign end_sat   = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
    assign new_end   = {1'b0, r_off} + {1'b0, r_need};
    assign prev_end  = {1'b0, r_prev.start} + {1'b0, r_prev.length};
    assign join_next = r_next_v && (new_end == {1'b0, r_next.start});
    assign join_prev = r_prev_v && (prev_end == {1'b0, r_off});

    always_comb begin
        len_sum = {2'b00, r_need};
        if (join_prev) begin
            len_sum = len_sum + {2'b00, r_prev.length};
        end
        if (join_next) begin
            len_sum = len_sum + {2'b00, r_next.length};
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_peak     = r_peak;
        n_need     = r_need;
        n_off      = r_off;
        n_granted  = r_granted;
        n_status   = r_status;
        n_raddr    = r_raddr;
        n_issue    = r_issue;
        n_found    = r_found;
        n_best_idx = r_best_idx;
        n_best     = r_best;
        n_prev     = r_prev;
        n_prev_v   = r_prev_v;
        n_next     = r_next;
        n_next_v   = r_next_v;
        n_pos      = r_pos;
        o_cmd      = '0;
        o_done     = 1'b0;

        // read issue shared by all walking states
        if (r_issue) begin
            o_cmd.re    = 1'b1;
            o_cmd.raddr = r_raddr;
        end

        unique case (r_state)
            S_INIT: begin
                o_cmd.we    = 1'b1;
                o_cmd.waddr = '0;
                o_cmd.wdata = '{start: 32'd0, length: full_len};
                n_state     = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_granted = 32'd0;
                    n_status  = bfia_pkg::ST_OK;
                    n_off     = i_req.block_offset;
                    n_need    = (i_req.req_size + 32'd15) & ~32'd15;
                    n_state   = S_RESP;
                    case (i_req.req_type) inside
                        bfia_pkg::REQ_RESTART: begin
                            o_cmd.we    = 1'b1;
                            o_cmd.waddr = '0;
                            o_cmd.wdata = '{start: 32'd0, length: full_len};
                            n_count     = CW'(1);
                            n_peak      = 32'd0;
                        end
                        bfia_pkg::REQ_ALLOC, bfia_pkg::REQ_FREE: begin
                            if (i_req.req_size == 32'd0) begin
                                n_state = S_RESP;
                            end else if (i_req.req_size > bfia_pkg::MAX_ROUNDABLE) begin
                                n_status = bfia_pkg::ST_NOSPACE;
                            end else if (i_req.req_type == bfia_pkg::REQ_ALLOC) begin
                                if (r_count == '0) begin
                                    n_status = bfia_pkg::ST_NOSPACE;
                                end else begin
                                    n_raddr = '0;
                                    n_issue = 1'b1;
                                    n_found = 1'b0;
                                    n_state = S_ASCAN;
                                end
                            end else begin
                                n_prev_v = 1'b0;
                                n_next_v = 1'b0;
                                n_pos    = r_count;
                                if (r_count == '0) begin
                                    n_state = S_FAPPLY;
                                end else begin
                                    n_raddr = '0;
                                    n_issue = 1'b1;
                                    n_state = S_FSCAN;
                                end
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_ASCAN: begin
                if (r_issue) begin
                    if (r_raddr == last_idx) begin
                        n_issue = 1'b0;
                    end else begin
                        n_raddr = r_raddr + AW'(1);
                    end
                end
                if (r_rvld) begin
                    if ((i_rdata.length >= r_need) &&
                        (!r_found || (i_rdata.length < r_best.length))) begin
                        n_best     = i_rdata;
                        n_best_idx = r_ridx;
                        n_found    = 1'b1;
                    end
                    if (r_ridx == last_idx) begin
                        n_state = S_AAPPLY;
                    end
                end
            end
            S_AAPPLY: begin
                n_state = S_RESP;
                if (!r_found) begin
                    n_status = bfia_pkg::ST_NOSPACE;
                end else begin
                    n_granted = r_best.start;
                    if (end_sat > r_peak) begin
                        n_peak = end_sat;
                    end
                    if (r_best.length == r_need) begin
                        // exact fit: close the gap above the entry
                        if (r_best_idx == last_idx) begin
                            n_count = r_count - CW'(1);
                        end else begin
                            n_raddr = r_best_idx + AW'(1);
                            n_issue = 1'b1;
                            n_state = S_SHDN;
                        end
                    end else begin
                        o_cmd.we    = 1'b1;
                        o_cmd.waddr = r_best_idx;
                        o_cmd.wdata = '{start:  r_best.start + r_need,
                                        length: r_best.length - r_need};
                    end
                end
            end
            S_FSCAN: begin
                if (r_issue) begin
                    if (r_raddr == last_idx) begin
                        n_issue = 1'b0;
                    end else begin
                        n_raddr = r_raddr + AW'(1);
                    end
                end
                if (r_rvld) begin
                    if (i_rdata.start < r_off) begin
                        n_prev   = i_rdata;
                        n_prev_v = 1'b1;
                        n_pos    = CW'(r_ridx) + CW'(1);
                        if (r_ridx == last_idx) begin
                            n_state = S_FAPPLY;
                        end
                    end else begin
                        n_next   = i_rdata;
                        n_next_v = 1'b1;
                        n_pos    = CW'(r_ridx);
                        n_issue  = 1'b0;
                        n_state  = S_FAPPLY;
                    end
                end
            end
            S_FAPPLY: begin
                n_state = S_RESP;
                n_issue = 1'b0;
                if (join_prev) begin
                    o_cmd.we    = 1'b1;
                    o_cmd.waddr = AW'(r_pos - CW'(1));
                    o_cmd.wdata = '{start: r_prev.start, length: sat32(len_sum)};
                    if (join_next) begin
                        if (AW'(r_pos) == last_idx) begin
                            n_count = r_count - CW'(1);
                        end else begin
                            n_raddr = AW'(r_pos) + AW'(1);
                            n_issue = 1'b1;
                            n_state = S_SHDN;
                        end
                    end
                end else if (join_next) begin
                    o_cmd.we    = 1'b1;
                    o_cmd.waddr = AW'(r_pos);
                    o_cmd.wdata = '{start: r_off, length: sat32(len_sum)};
                end else if (r_count >= CW'(bfia_pkg::MAX_FREE_BLOCKS)) begin
                    n_status = bfia_pkg::ST_FULL;
                end else if (r_pos == r_count) begin
                    o_cmd.we    = 1'b1;
                    o_cmd.waddr = AW'(r_pos);
                    o_cmd.wdata = '{start: r_off, length: r_need};
                    n_count     = r_count + CW'(1);
                end else begin
                    // open a slot: move entries up from the top down
                    n_raddr = last_idx;
                    n_issue = 1'b1;
                    n_state = S_SHUP;
                end
            end
            S_SHDN: begin
                if (r_issue) begin
                    if (r_raddr == last_idx) begin
                        n_issue = 1'b0;
                    end else begin
                        n_raddr = r_raddr + AW'(1);
                    end
                end
                if (r_rvld) begin
                    o_cmd.we    = 1'b1;
                    o_cmd.waddr = r_ridx - AW'(1);
                    o_cmd.wdata = i_rdata;
                    if (r_ridx == last_idx) begin
                        n_count = r_count - CW'(1);
                        n_state = S_RESP;
                    end
                end
            end
            S_SHUP: begin
                if (r_issue) begin
                    if (r_raddr == AW'(r_pos)) begin
                        n_issue = 1'b0;
                    end else begin
                        n_raddr = r_raddr - AW'(1);
                    end
                end
                if (r_rvld) begin
                    o_cmd.we    = 1'b1;
                    o_cmd.waddr = r_ridx + AW'(1);
                    o_cmd.wdata = i_rdata;
                    if (r_ridx == AW'(r_pos)) begin
                        n_state = S_FINS;
                    end
                end
            end
            S_FINS: begin
                o_cmd.we    = 1'b1;
                o_cmd.waddr = AW'(r_pos);
                o_cmd.wdata = '{start: r_off, length: r_need};
                n_count     = r_count + CW'(1);
                n_state     = S_RESP;
            end
            S_RESP: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_count <= CW'(1);
            r_peak  <= 32'd0;
            r_issue <= 1'b0;
            r_rvld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_peak  <= n_peak;
            r_issue <= n_issue;
            r_rvld  <= o_cmd.re;
        end
    end

    always_ff @(posedge i_clk) begin
        r_need     <= n_need;
        r_off      <= n_off;
        r_granted  <= n_granted;
        r_status   <= n_status;
        r_raddr    <= n_raddr;
        r_ridx     <= o_cmd.raddr;
        r_found    <= n_found;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_prev     <= n_prev;
        r_prev_v   <= n_prev_v;
        r_next     <= n_next;
        r_next_v   <= n_next_v;
        r_pos      <= n_pos;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_rsp   = '{granted_offset: r_granted, status: r_status, peak_end: r_peak};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(bfia_pkg::MAX_FREE_BLOCKS))
        else $error("free table count above capacity");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_status == bfia_pkg::ST_FULL) |->
            r_count == CW'(bfia_pkg::MAX_FREE_BLOCKS))
        else $error("table full reported below capacity");

    a_restart_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && i_req.req_type == bfia_pkg::REQ_RESTART) |=>
            (r_count == CW'(1) && r_peak == 32'd0))
        else $error("restart did not reset table");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.re |-> ({1'b0, o_cmd.raddr} < r_count))
        else $error("read beyond live entries");
`endif

endmodule

@@ hdl/best_fit_interval_allocator_unit.sv @@
// Top level: register port, request/response handshakes, table and sequencer.
//
//  channel | direction | handshake                    | payload
//  req     | in        | i_req_valid / o_req_ready    | i_req  (bfia_pkg::t_req)
//  rsp     | out       | o_rsp_valid / i_rsp_ready    | o_rsp  (bfia_pkg::t_rsp)
//  cfg     | in        | psel, penable, pwrite, pready| arena_size at byte address 0
//
//  One request at a time. Allocate: a best-fit scan of every entry through the
//  single table read port, plus a shift down of the entries above the best fit
//  when an exact fit closes the gap. Free: an ordered walk up to the first entry
//  at or above the offset, plus an insertion shift, or a shift down for a double
//  merge. Restart and trivial requests go straight to the response.
//  After reset the sequencer writes the initial interval, then goes idle.
//  A waiting response is held in the output register; the sequencer stalls until
//  it is free, then returns to idle to take the next request.
`timescale 1ns / 1ps
module best_fit_interval_allocator_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  bfia_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output bfia_pkg::t_rsp  o_rsp,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam logic REG_ARENA = 1'b0;

    logic                arena_hit;
    logic [31:0]         r_arena_size;
    logic                r_rsp_valid;
    bfia_pkg::t_rsp      r_rsp;
    logic                out_free;
    logic                start;
    logic                done;
    logic                ready;
    bfia_pkg::t_rsp      ctrl_rsp;
    bfia_pkg::t_tbl_cmd  tbl_cmd;
    bfia_pkg::t_entry    tbl_rdata;

    assign pready    = 1'b1;
    assign arena_hit = (paddr[2] == REG_ARENA);
    assign prdata    = arena_hit ? r_arena_size : 32'd0;
    assign out_free  = !r_rsp_valid || i_rsp_ready;
    assign start     = i_req_valid && ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena_size <= 32'd0;
            r_rsp_valid  <= 1'b0;
        end else begin
            if (psel && penable && pwrite && arena_hit) begin
                r_arena_size <= pwdata;
            end
            if (done) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_rsp <= ctrl_rsp;
        end
    end

    bfia_table u_table (
        .i_clk   (i_clk),
        .i_cmd   (tbl_cmd),
        .o_rdata (tbl_rdata)
    );

    bfia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req      (i_req),
        .i_arena    (r_arena_size),
        .i_out_free (out_free),
        .o_ready    (ready),
        .o_done     (done),
        .o_rsp      (ctrl_rsp),
        .o_cmd      (tbl_cmd),
        .i_rdata    (tbl_rdata)
    );

    assign o_req_ready = ready;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule
